@@ design/tacho_period_smoother_rpm_macros.svh @@
// Assertion macros for the tachometer period smoother.
`ifndef TACHO_PERIOD_SMOOTHER_RPM_MACROS_SVH
`define TACHO_PERIOD_SMOOTHER_RPM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/tps_pkg.sv @@
// Shared constants for the tachometer period smoother.
`default_nettype none
package tps_pkg;
	localparam int PERIOD_WIDTH = 16;
	localparam int OUT_PER_W    = 16;
	localparam int IN_PER_W     = 16;
	localparam int WEIGHT_W     = 8;
	localparam int SCALE_W      = 32;
	localparam int RPM_W        = 32;
	localparam int WSUM_W       = WEIGHT_W + 1;
	localparam int PROD_W       = PERIOD_WIDTH + WEIGHT_W;
	localparam int ACC_W        = PROD_W + 1;
	localparam int NUM_W        = (ACC_W > SCALE_W) ? ACC_W : SCALE_W;
	localparam int DEN_W        = (PERIOD_WIDTH > WSUM_W) ? PERIOD_WIDTH : WSUM_W;
	localparam int CNT_W        = $clog2(NUM_W);
	localparam int CFG_IDX_W    = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_OLD_WEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NEW_WEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RPM_SCALE  = 2'd2;

	localparam logic [WEIGHT_W-1:0] OLD_WEIGHT_RST = 8'd3;
	localparam logic [WEIGHT_W-1:0] NEW_WEIGHT_RST = 8'd1;
	localparam logic [SCALE_W-1:0]  RPM_SCALE_RST  = 32'd60000000;

	localparam logic OP_CAPTURE  = 1'b0;
	localparam logic OP_OVERFLOW = 1'b1;
endpackage
`default_nettype wire

@@ design/tacho_period_smoother_rpm.sv @@
// Top level of the tachometer period smoother with RPM output.
//
//   Channel   Signals                                   Direction
//   in        in_valid, in_ready, opcode, period        into block
//   out       out_valid, out_ready, smoothed_period, rpm out of block
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data  into block
//
// A capture passes from the accepting cycle through the multiply states MUL1 and MUL2,
// the divide for the average in DIV1, the divide for the RPM in DIV2 and the result load.
// A zero weight sum skips to the RPM division; an overflow goes straight to the load.
// One restoring divider, one bit per cycle, serves both divisions.
// The result register frees the input side: a new item is taken once the
// previous result is loaded, and loading waits while the result is not taken.
// Reset restores the register defaults and clears the average.
`default_nettype none
`include "tacho_period_smoother_rpm_macros.svh"
module tacho_period_smoother_rpm
	import tps_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 opcode,
	input  wire logic [IN_PER_W-1:0]  period,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [OUT_PER_W-1:0]      smoothed_period,
	output logic [RPM_W-1:0]          rpm,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SCALE_W-1:0]   cfg_data
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_MUL2 = 3'd2;
	localparam logic [2:0] ST_DIV1 = 3'd3;
	localparam logic [2:0] ST_DIV2 = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]              state_q;
	logic [WEIGHT_W-1:0]     old_weight_q;
	logic [WEIGHT_W-1:0]     new_weight_q;
	logic [SCALE_W-1:0]      rpm_scale_q;
	logic [PERIOD_WIDTH-1:0] avg_q;
	logic [PERIOD_WIDTH-1:0] per_q;
	logic [ACC_W-1:0]        acc_q;
	logic [NUM_W-1:0]        num_q;
	logic [DEN_W-1:0]        rem_q;
	logic [DEN_W-1:0]        den_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    out_valid_q;
	logic [OUT_PER_W-1:0]    out_per_q;
	logic [RPM_W-1:0]        out_rpm_q;

	logic                    in_acc;
	logic [WSUM_W-1:0]       wsum;
	logic [PERIOD_WIDTH-1:0] mul_a;
	logic [WEIGHT_W-1:0]     mul_b;
	logic [PROD_W-1:0]       prod;
	logic [DEN_W:0]          rem_sh;
	logic [DEN_W+1:0]        diff;
	logic                    borrow;
	logic                    div_last;
	logic                    out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign wsum      = WSUM_W'(old_weight_q) + WSUM_W'(new_weight_q);

	assign mul_a = (state_q == ST_MUL1) ? avg_q : per_q;
	assign mul_b = (state_q == ST_MUL1) ? old_weight_q : new_weight_q;
	assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

	assign rem_sh   = {rem_q, num_q[NUM_W-1]};
	assign diff     = {1'b0, rem_sh} - {2'b00, den_q};
	assign borrow   = diff[DEN_W+1];
	assign div_last = (cnt_q == CNT_W'(NUM_W - 1));
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_weight_q <= OLD_WEIGHT_RST;
			new_weight_q <= NEW_WEIGHT_RST;
			rpm_scale_q  <= RPM_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_OLD_WEIGHT: old_weight_q <= cfg_data[WEIGHT_W-1:0];
				CFG_NEW_WEIGHT: new_weight_q <= cfg_data[WEIGHT_W-1:0];
				CFG_RPM_SCALE:  rpm_scale_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			avg_q       <= '0;
			per_q       <= '0;
			acc_q       <= '0;
			num_q       <= '0;
			rem_q       <= '0;
			den_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_per_q   <= '0;
			out_rpm_q   <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (opcode == OP_OVERFLOW) begin
							avg_q   <= '0;
							state_q <= ST_OUT;
						end else if (wsum == '0) begin
							num_q   <= NUM_W'(rpm_scale_q);
							den_q   <= DEN_W'(avg_q);
							rem_q   <= '0;
							cnt_q   <= '0;
							state_q <= ST_DIV2;
						end else begin
							per_q   <= PERIOD_WIDTH'(period);
							state_q <= ST_MUL1;
						end
					end
				end
				ST_MUL1: begin
					acc_q   <= ACC_W'(prod);
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					num_q   <= NUM_W'(acc_q + ACC_W'(prod));
					den_q   <= DEN_W'(wsum);
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV1;
				end
				ST_DIV1, ST_DIV2: begin
					if (!div_last) begin
						num_q <= {num_q[NUM_W-2:0], !borrow};
						rem_q <= borrow ? rem_sh[DEN_W-1:0] : diff[DEN_W-1:0];
						cnt_q <= cnt_q + 1'b1;
					end else if (state_q == ST_DIV1) begin
						// The last quotient bit completes the new average.
						avg_q   <= PERIOD_WIDTH'({num_q[NUM_W-2:0], !borrow});
						num_q   <= NUM_W'(rpm_scale_q);
						den_q   <= DEN_W'({num_q[NUM_W-2:0], !borrow});
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV2;
					end else begin
						num_q   <= {num_q[NUM_W-2:0], !borrow};
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_per_q   <= OUT_PER_W'(avg_q);
						out_rpm_q   <= (avg_q == '0) ? '0 : RPM_W'(num_q);
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign smoothed_period = out_per_q;
	assign rpm             = out_rpm_q;

	`TPS_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready,
		"Sequencer stayed idle after taking an item.")
	`TPS_ASSERT_NEXT(a_overflow_clears, in_acc && (opcode == OP_OVERFLOW), avg_q == '0,
		"Overflow event did not clear the average.")
	`TPS_ASSERT_SAME(a_zero_period_rpm, out_valid && (smoothed_period == '0), rpm == '0,
		"Nonzero RPM reported for a zero period.")
endmodule
`default_nettype wire

@@ tb/tacho_period_smoother_rpm_tb.sv @@
// Self-checking testbench for the tachometer period smoother with RPM output.
`timescale 1ns / 1ps
module tacho_period_smoother_rpm_tb
	import tps_pkg::*;
;
	typedef struct packed {
		logic [OUT_PER_W-1:0] smoothed;
		logic [RPM_W-1:0]     rpm;
	} speed_result_t;

	class speed_tracker;
		bit [WEIGHT_W-1:0]     old_w;
		bit [WEIGHT_W-1:0]     new_w;
		bit [SCALE_W-1:0]      scale;
		bit [PERIOD_WIDTH-1:0] avg;
		speed_result_t         expected_speeds[$];
		int                    mismatches;

		function new();
			old_w = OLD_WEIGHT_RST;
			new_w = NEW_WEIGHT_RST;
			scale = RPM_SCALE_RST;
			avg = '0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SCALE_W-1:0] data);
			case (idx)
				CFG_OLD_WEIGHT: old_w = data[WEIGHT_W-1:0];
				CFG_NEW_WEIGHT: new_w = data[WEIGHT_W-1:0];
				CFG_RPM_SCALE:  scale = data;
				default: ;
			endcase
		endfunction

		function void note_event(logic op, logic [IN_PER_W-1:0] per);
			bit [WSUM_W-1:0] wsum;
			bit [ACC_W-1:0]  acc;
			speed_result_t   res;
			wsum = WSUM_W'(old_w) + WSUM_W'(new_w);
			if (op == OP_OVERFLOW) begin
				avg = '0;
			end else if (wsum != 0) begin
				acc = ACC_W'(avg) * ACC_W'(old_w) + ACC_W'(per) * ACC_W'(new_w);
				avg = PERIOD_WIDTH'(acc / ACC_W'(wsum));
			end
			res.smoothed = OUT_PER_W'(avg);
			res.rpm = (avg == 0) ? '0 : RPM_W'(scale / SCALE_W'(avg));
			expected_speeds.push_back(res);
		endfunction

		function void check_speed(logic [OUT_PER_W-1:0] sp, logic [RPM_W-1:0] r);
			speed_result_t want;
			if (expected_speeds.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: smoothed_period=%0d rpm=%0d", sp, r);
				return;
			end
			want = expected_speeds.pop_front();
			if (sp !== want.smoothed || r !== want.rpm) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: smoothed_period exp %0d got %0d, rpm exp %0d got %0d",
						want.smoothed, sp, want.rpm, r);
			end
		endfunction

		function int pending();
			return expected_speeds.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 opcode = OP_CAPTURE;
	logic [IN_PER_W-1:0]  period = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [OUT_PER_W-1:0] smoothed_period;
	logic [RPM_W-1:0]     rpm;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_OLD_WEIGHT;
	logic [SCALE_W-1:0]   cfg_data = '0;
	bit                   hold_req = 1'b0;

	speed_tracker tracker = new();

	tacho_period_smoother_rpm u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.period(period),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.smoothed_period(smoothed_period),
		.rpm(rpm),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end

	// Notes each accepted request and register write, and checks each result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.set_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				tracker.note_event(opcode, period);
			if (out_valid && out_ready)
				tracker.check_speed(smoothed_period, rpm);
		end
	end

	initial begin
		int  hold_left;
		int  mode;
		int  mode_left;
		int  tick;
		bit  rdy;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(10, 200);
				end
				mode_left--;
				case (mode)
					0: rdy = 1'b1;
					1: rdy = 1'($urandom_range(0, 1));
					2: rdy = ($urandom_range(0, 7) == 0);
					default: rdy = ((tick % 7) < 3);
				endcase
			end
			out_ready <= rdy;
		end
	end

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return WEIGHT_W'(1);
			default: return WEIGHT_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [SCALE_W-1:0] pick_scale();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return SCALE_W'(1);
			3: return RPM_SCALE_RST;
			default: return SCALE_W'($urandom);
		endcase
	endfunction

	function automatic logic [IN_PER_W-1:0] pick_period();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return IN_PER_W'($urandom_range(0, 15));
			3: return IN_PER_W'($urandom_range(16, 1023));
			default: return IN_PER_W'($urandom);
		endcase
	endfunction

	function automatic logic pick_op();
		return ($urandom_range(0, 9) == 0) ? OP_OVERFLOW : OP_CAPTURE;
	endfunction

	task automatic send_event(input logic op, input logic [IN_PER_W-1:0] per);
		in_valid <= 1'b1;
		opcode <= op;
		period <= per;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic program_regs(input logic [WEIGHT_W-1:0] ow, input logic [WEIGHT_W-1:0] nw,
		input logic [SCALE_W-1:0] sc);
		write_reg(CFG_OLD_WEIGHT, SCALE_W'(ow));
		write_reg(CFG_NEW_WEIGHT, SCALE_W'(nw));
		write_reg(CFG_RPM_SCALE, sc);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic run_traffic(input int count, input bit no_gaps);
		int sent;
		int burst;
		int gap;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 16);
			for (int i = 0; i < burst && sent < count; i++) begin
				send_event(pick_op(), pick_period());
				sent++;
			end
			if (no_gaps)
				gap = 0;
			else if ($urandom_range(0, 4) == 0)
				gap = $urandom_range(30, 100);
			else
				gap = $urandom_range(0, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Reset weights and scale; a zero average gives zero rpm.
		send_event(OP_CAPTURE, '0);
		send_event(OP_CAPTURE, '1);
		send_event(OP_CAPTURE, '1);
		send_event(OP_CAPTURE, 16'hAAAA);
		send_event(OP_OVERFLOW, '1);
		send_event(OP_CAPTURE, 16'h5555);
		send_event(OP_CAPTURE, 16'd1);
		drain();

		// A zero weight sum holds the average.
		program_regs('0, '0, RPM_SCALE_RST);
		send_event(OP_CAPTURE, 16'd1234);
		send_event(OP_CAPTURE, '1);
		send_event(OP_OVERFLOW, '0);
		send_event(OP_CAPTURE, '1);
		drain();

		program_regs('0, '1, '1);
		send_event(OP_CAPTURE, 16'd1);
		send_event(OP_CAPTURE, '1);
		send_event(OP_OVERFLOW, 16'h5555);
		drain();

		program_regs('1, '1, 32'd1);
		send_event(OP_CAPTURE, '1);
		send_event(OP_CAPTURE, '0);
		drain();

		program_regs('1, '0, '0);
		send_event(OP_CAPTURE, 16'd777);
		drain();
		program_regs('1, '0, '1);
		send_event(OP_CAPTURE, 16'd777);
		send_event(OP_CAPTURE, '1);
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			program_regs(pick_weight(), pick_weight(), pick_scale());
			if (phase == 3) begin
				hold_req = 1'b1;
				run_traffic(30, 1'b1);
			end else begin
				run_traffic(50, phase == 5);
			end
			drain();
		end

		repeat (100) @(negedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+design
design/tps_pkg.sv
design/tacho_period_smoother_rpm.sv
tb/tacho_period_smoother_rpm_tb.sv
